// ===== hdl/ad_uuid16_filter_addr_compare_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the UUID16 advertising filter
// Clocked assertion wrappers, disabled while the active-low reset is low.
// The macros are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef AD_UUID16_FILTER_ADDR_COMPARE_ASSERT_SVH
`define AD_UUID16_FILTER_ADDR_COMPARE_ASSERT_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define ADU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ADU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ADU_ASSERT(label, clk, rst_n, prop, msg)
`define ADU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/adu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adu_pkg
// Shared widths and constants of the UUID16 advertising filter.
// ----------------------------------------------------------------------------
package adu_pkg;

    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 32;
    localparam int FIELD_W     = 9;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int MAX_PAYLOAD_DEF = 255;

    localparam logic [BYTE_W-1:0] TYPE_UUID16_LIST = 8'h03;
    localparam logic [BYTE_W-1:0] UUID_LO          = 8'h6F;
    localparam logic [BYTE_W-1:0] UUID_HI          = 8'hFD;

    // Register index, taken from paddr[2].
    typedef enum logic [0:0] {
        REG_LOCAL_ADDR_LOW = 1'b0,
        REG_UNUSED         = 1'b1
    } t_reg_idx;

endpackage

// ===== hdl/adu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adu_byte_if / adu_result_if
// Valid/ready channels for payload bytes in and match results out.
// ----------------------------------------------------------------------------
interface adu_byte_if import adu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic [ADDR_W-1:0] peer_addr_low;
    logic              end_of_packet;

    modport source (output valid, payload_byte, peer_addr_low, end_of_packet, input ready);
    modport sink   (input valid, payload_byte, peer_addr_low, end_of_packet, output ready);
endinterface

interface adu_result_if ();
    logic valid;
    logic ready;
    logic match;

    modport source (output valid, match, input ready);
    modport sink   (input valid, match, output ready);
endinterface

// ===== hdl/ad_uuid16_filter_addr_compare.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ad_uuid16_filter_addr_compare
// Walks advertising length/type structures byte by byte, flags a 16-bit
// service UUID list whose first entry is 0xFD6F, and on the last byte reports a match when
// the flag is set and the local address word is below the peer's.
// ----------------------------------------------------------------------------
// Throughput: one payload beat per cycle; the parser state updates at accept.
// The result beat is registered and is valid in the cycle after the last byte is accepted.
// A result beat that waits on a stalled sink holds off the payload channel.
// Reset (synchronous, active low) clears the parser, the result valid flag and the
// local address register.

`include "ad_uuid16_filter_addr_compare_assert.svh"

module ad_uuid16_filter_addr_compare
    import adu_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    adu_byte_if.sink              i_byte,
    adu_result_if.source          o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int POS_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PAYLOAD);

    logic [ADDR_W-1:0]  r_local_addr;
    logic [POS_W-1:0]   r_byte_position, n_byte_position;
    logic [FIELD_W-1:0] r_next_field_start, n_next_field_start;
    logic [BYTE_W-1:0]  r_recent0, n_recent0;
    logic [BYTE_W-1:0]  r_recent1, n_recent1;
    logic [2:0]         r_start_marks, n_start_marks;
    logic               r_service_hit, n_service_hit;
    logic               r_out_valid, n_out_valid;
    logic               r_match, n_match;

    t_reg_idx w_reg_idx;
    logic     w_cfg_write;
    logic     w_in_accept;
    logic     w_parse;
    logic     w_is_start;
    logic     w_hit_now;
    logic     w_hit_total;

    // ---------------- configuration port ----------------
    assign pready      = 1'b1;
    assign w_reg_idx   = t_reg_idx'(paddr[2]);
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (w_reg_idx)
            REG_LOCAL_ADDR_LOW: prdata = r_local_addr;
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= '0;
        end else if (w_cfg_write && (w_reg_idx == REG_LOCAL_ADDR_LOW)) begin
            r_local_addr <= pwdata;
        end
    end

    // ---------------- parser ----------------
    assign i_byte.ready = !r_out_valid || o_result.ready;
    assign w_in_accept  = i_byte.valid && i_byte.ready;

    // Bytes past the payload limit are not parsed, but the last one still ends the packet.
    assign w_parse    = r_byte_position < POS_LIMIT;
    assign w_is_start = r_next_field_start == FIELD_W'(r_byte_position);
    // A field that began three beats back: type byte, then the two UUID bytes.
    assign w_hit_now  = r_start_marks[2] && (r_recent1 == TYPE_UUID16_LIST) &&
                        (r_recent0 == UUID_LO) && (i_byte.payload_byte == UUID_HI);
    assign w_hit_total = r_service_hit || (w_parse && w_hit_now);

    always_comb begin
        n_byte_position    = r_byte_position;
        n_next_field_start = r_next_field_start;
        n_recent0          = r_recent0;
        n_recent1          = r_recent1;
        n_start_marks      = r_start_marks;
        n_service_hit      = r_service_hit;
        if (w_in_accept) begin
            if (w_parse) begin
                if (w_is_start) begin
                    n_next_field_start = FIELD_W'(r_byte_position) +
                                         FIELD_W'(i_byte.payload_byte) + FIELD_W'(1);
                end
                n_service_hit   = w_hit_total;
                n_recent1       = r_recent0;
                n_recent0       = i_byte.payload_byte;
                n_start_marks   = {r_start_marks[1:0], w_is_start};
                n_byte_position = r_byte_position + POS_W'(1);
            end
            if (i_byte.end_of_packet) begin
                n_byte_position    = '0;
                n_next_field_start = '0;
                n_recent0          = '0;
                n_recent1          = '0;
                n_start_marks      = '0;
                n_service_hit      = 1'b0;
            end
        end
    end

    // ---------------- result register ----------------
    always_comb begin
        n_out_valid = r_out_valid;
        n_match     = r_match;
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_in_accept && i_byte.end_of_packet) begin
            n_out_valid = 1'b1;
            n_match     = w_hit_total && (r_local_addr < i_byte.peer_addr_low);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position    <= '0;
            r_next_field_start <= '0;
            r_recent0          <= '0;
            r_recent1          <= '0;
            r_start_marks      <= '0;
            r_service_hit      <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            r_byte_position    <= n_byte_position;
            r_next_field_start <= n_next_field_start;
            r_recent0          <= n_recent0;
            r_recent1          <= n_recent1;
            r_start_marks      <= n_start_marks;
            r_service_hit      <= n_service_hit;
            r_out_valid        <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_match <= n_match;
    end

    assign o_result.valid = r_out_valid;
    assign o_result.match = r_match;

    // ---------------- assertions ----------------
    `ADU_ASSERT(a_pos_bound, i_clk, i_rst_n, r_byte_position <= POS_LIMIT, "position past limit")
    `ADU_ASSERT_NEXT(a_eop_clears, i_clk, i_rst_n, w_in_accept && i_byte.end_of_packet, (r_byte_position == '0) && !r_service_hit && (r_start_marks == '0), "parser not cleared after last byte")
    `ADU_ASSERT_NEXT(a_eop_result, i_clk, i_rst_n, w_in_accept && i_byte.end_of_packet, r_out_valid, "no result after last byte")
    `ADU_ASSERT(a_result_source, i_clk, i_rst_n, !$rose(r_out_valid) || $past(w_in_accept && i_byte.end_of_packet), "result without a last byte")

endmodule
